// ----- rtl/core/utf8_decode_validate_cjk_unit_defines.svh -----
// Assertion macros shared by the UTF-8 decoder checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UTF8_DECODE_VALIDATE_CJK_UNIT_DEFINES_SVH
`define UTF8_DECODE_VALIDATE_CJK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8DV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8DV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/u8dv_pkg.sv -----
// Package for the UTF-8 decoder: decoder state and result types, byte and scalar
// constants, the ideograph range and scalar check functions. Depends on nothing.
package u8dv_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [7:0] Lead2Min = 8'hC2;
	localparam logic [7:0] Lead2Max = 8'hDF;
	localparam logic [7:0] Lead4Min = 8'hF0;
	localparam logic [7:0] Lead4Max = 8'hF4;

	localparam logic [CpW-1:0] ScalarMax    = 21'h10FFFF;
	localparam logic [CpW-1:0] SurrogateLo  = 21'h00D800;
	localparam logic [CpW-1:0] SurrogateHi  = 21'h00DFFF;
	localparam logic [CpW-1:0] Min2Byte     = 21'h000080;
	localparam logic [CpW-1:0] Min3Byte     = 21'h000800;
	localparam logic [CpW-1:0] Min4Byte     = 21'h010000;

	localparam logic [CpW-1:0] CjkExtALo    = 21'h003400;
	localparam logic [CpW-1:0] CjkExtAHi    = 21'h004DBF;
	localparam logic [CpW-1:0] CjkUniLo     = 21'h004E00;
	localparam logic [CpW-1:0] CjkUniHi     = 21'h009FFF;
	localparam logic [CpW-1:0] CjkCompatLo  = 21'h00F900;
	localparam logic [CpW-1:0] CjkCompatHi  = 21'h00FAFF;
	localparam logic [CpW-1:0] CjkSuppLo    = 21'h020000;
	localparam logic [CpW-1:0] CjkSuppHi    = 21'h02FA1F;

	// Sequence length minus one, as held while a multi-byte sequence is open.
	localparam logic [1:0] SeqTwo   = 2'd1;
	localparam logic [1:0] SeqThree = 2'd2;

	typedef struct packed {
		logic [1:0]     pending;
		logic [CpW-1:0] partial;
		logic [1:0]     seqlen;
		logic           err;
		logic           ideo;
	} dec_state_t;

	typedef struct packed {
		logic           char_done;
		logic [CpW-1:0] codepoint;
		logic           char_is_cjk;
		logic           string_bad;
		logic           string_end;
		logic           string_valid;
		logic           string_has_cjk;
	} dec_result_t;

	function automatic logic in_cjk(input logic [CpW-1:0] cp);
		in_cjk = (cp >= CjkExtALo && cp <= CjkExtAHi) ||
			(cp >= CjkUniLo && cp <= CjkUniHi) ||
			(cp >= CjkCompatLo && cp <= CjkCompatHi) ||
			(cp >= CjkSuppLo && cp <= CjkSuppHi);
	endfunction

	function automatic logic scalar_ok(input logic [CpW-1:0] cp, input logic [1:0] seqlen);
		logic [CpW-1:0] minimum;
		case (seqlen)
			SeqTwo:   minimum = Min2Byte;
			SeqThree: minimum = Min3Byte;
			default:  minimum = Min4Byte;
		endcase
		scalar_ok = (cp >= minimum) && (cp <= ScalarMax) &&
			!(cp >= SurrogateLo && cp <= SurrogateHi);
	endfunction

endpackage

// ----- rtl/core/u8dv_step.sv -----
// Combinational decode step: one byte against the current decoder state,
// giving the next state and the result beat. Depends on u8dv_pkg.
module u8dv_step (
	input  u8dv_pkg::dec_state_t  cur,
	input  logic [7:0]            text_byte,
	input  logic                  last_byte,
	output u8dv_pkg::dec_state_t  nxt,
	output u8dv_pkg::dec_result_t res
);
	import u8dv_pkg::*;

	logic [CpW-1:0] assembled;
	logic           done;
	logic [CpW-1:0] cp;
	dec_state_t     upd;

	assign assembled = {cur.partial[CpW-7:0], text_byte[5:0]};

	always_comb begin
		upd  = cur;
		done = 1'b0;
		cp   = '0;
		if (!cur.err) begin
			if (cur.pending == 2'd0) begin
				if (!text_byte[7]) begin
					done = 1'b1;
					cp   = {{(CpW-8){1'b0}}, text_byte};
				end else if (text_byte >= Lead2Min && text_byte <= Lead2Max) begin
					upd.pending = 2'd1;
					upd.seqlen  = 2'd1;
					upd.partial = {{(CpW-5){1'b0}}, text_byte[4:0]};
				end else if (text_byte[7:4] == 4'hE) begin
					upd.pending = 2'd2;
					upd.seqlen  = 2'd2;
					upd.partial = {{(CpW-4){1'b0}}, text_byte[3:0]};
				end else if (text_byte >= Lead4Min && text_byte <= Lead4Max) begin
					upd.pending = 2'd3;
					upd.seqlen  = 2'd3;
					upd.partial = {{(CpW-3){1'b0}}, text_byte[2:0]};
				end else begin
					upd.err = 1'b1;
				end
			end else if (text_byte[7:6] != 2'b10) begin
				upd.err = 1'b1;
			end else begin
				upd.pending = cur.pending - 2'd1;
				if (cur.pending == 2'd1) begin
					if (scalar_ok(assembled, cur.seqlen)) begin
						done = 1'b1;
						cp   = assembled;
					end else begin
						upd.err = 1'b1;
					end
					upd.partial = '0;
					upd.seqlen  = '0;
				end else begin
					upd.partial = assembled;
				end
			end
			if (done && in_cjk(cp)) begin
				upd.ideo = 1'b1;
			end
			if (last_byte && upd.pending != 2'd0) begin
				upd.err = 1'b1;
			end
		end
	end

	always_comb begin
		res.char_done      = done;
		res.codepoint      = cp;
		res.char_is_cjk    = done && in_cjk(cp);
		res.string_bad     = upd.err;
		res.string_end     = last_byte;
		res.string_valid   = last_byte && !upd.err;
		res.string_has_cjk = last_byte && upd.ideo;
		// The final byte of a string returns the decoder to its reset state.
		nxt = last_byte ? '0 : upd;
	end

endmodule

// ----- rtl/core/utf8_decode_validate_cjk_unit.sv -----
// Streaming strict UTF-8 decoder with ideograph flagging, one beat per byte.
// A byte accepted at the input is held in the input stage, decoded combinationally, and its
// result beat is registered in the result stage, where it waits for the consumer.
// Throughput: one byte per cycle. With both stages full, in_ready follows out_ready
// combinationally, so a byte is then taken only in a cycle in which a result is taken.
// Reset (arst_n low, asynchronous) empties both stages and clears the state.
module utf8_decode_validate_cjk_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                text_byte,
	input  logic                      last_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      char_done,
	output logic [u8dv_pkg::CpW-1:0]  codepoint,
	output logic                      char_is_cjk,
	output logic                      string_bad,
	output logic                      string_end,
	output logic                      string_valid,
	output logic                      string_has_cjk
);
	import u8dv_pkg::*;

	// Input stage: the accepted byte waits here for the decode step.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Result stage: one decoded beat waiting for the consumer.
	logic        valid_s2;
	dec_result_t res_s2;

	// Decoder state carried from byte to byte within a string.
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res_nxt;

	logic        s2_free;
	logic        s1_move;

	// The result stage can take a new beat when it is empty or being drained.
	assign s2_free  = !valid_s2 || out_ready;
	// The input stage moves on whenever the result stage has room.
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	u8dv_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Control registers: stage occupancy and the decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s1_move) begin
				state_q <= state_nxt;
			end
		end
	end

	// Payload registers carry no reset; their valid bits guard them.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
		if (s1_move) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign char_done      = res_s2.char_done;
	assign codepoint      = res_s2.codepoint;
	assign char_is_cjk    = res_s2.char_is_cjk;
	assign string_bad     = res_s2.string_bad;
	assign string_end     = res_s2.string_end;
	assign string_valid   = res_s2.string_valid;
	assign string_has_cjk = res_s2.string_has_cjk;

endmodule

// ----- rtl/core/u8dv_checker.sv -----
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on u8dv_pkg and the assertion macros header.
`include "utf8_decode_validate_cjk_unit_defines.svh"

module u8dv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [7:0]                text_byte,
	input logic                      last_byte,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      char_done,
	input logic [u8dv_pkg::CpW-1:0]  codepoint,
	input logic                      char_is_cjk,
	input logic                      string_bad,
	input logic                      string_end,
	input logic                      string_valid,
	input logic                      string_has_cjk
);
	import u8dv_pkg::*;

	// A completed character never carries the bad mark of its own string.
	`U8DV_ASSERT_NOW(a_done_not_bad, clk, arst_n, out_valid && char_done, !string_bad, "char completed in a bad string")

	// Without a completed character the code point and its flag read as zero.
	`U8DV_ASSERT_NOW(a_idle_cp_zero, clk, arst_n, out_valid && !char_done, (codepoint == '0) && !char_is_cjk, "code point shown without a completed char")

	// Verdict fields stay low except on the final beat of a string.
	`U8DV_ASSERT_NOW(a_verdict_at_end, clk, arst_n, out_valid && !string_end, !string_valid && !string_has_cjk, "verdict shown before end of string")

	// A valid verdict and the bad mark are mutually exclusive.
	`U8DV_ASSERT_NOW(a_valid_vs_bad, clk, arst_n, out_valid && string_end, string_valid != string_bad, "verdict disagrees with bad mark")

	// A stalled result beat holds its code point.
	`U8DV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(codepoint), "stalled result beat changed")

endmodule

bind utf8_decode_validate_cjk_unit u8dv_checker u_u8dv_checker (.*);
